// ===== design/ppc_pkg.sv =====
// Shared types, constants and arithmetic helpers of the particle predictor-corrector.
package ppc_pkg;

    localparam int unsigned MAX_PARTICLES = 4096;
    localparam int unsigned ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int unsigned IDX_W         = 12;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned DT_W          = 31;
    localparam int unsigned PROD_W        = 64;
    localparam int unsigned RND_W         = PROD_W - 16;
    localparam int unsigned SUM_W         = 50;

    localparam logic [1:0] MODE_PREDICT = 2'd0;
    localparam logic [1:0] MODE_CORRECT = 2'd1;
    localparam logic [1:0] MODE_RANDOM  = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]               mode;
        logic [IDX_W-1:0]         particle_index;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] kick_x;
        logic signed [DATA_W-1:0] kick_y;
        logic signed [DATA_W-1:0] accel_x;
        logic signed [DATA_W-1:0] accel_y;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [DATA_W-1:0] new_pos_x;
        logic signed [DATA_W-1:0] new_pos_y;
        logic signed [DATA_W-1:0] new_vel_x;
        logic signed [DATA_W-1:0] new_vel_y;
        logic                     overflow;
    } t_out_item;

    // start values of one particle
    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
    } t_start;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_start            data;
    } t_store_wr;

    // item after the kick has been applied
    typedef struct packed {
        logic [1:0]               mode;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] accel_x;
        logic signed [DATA_W-1:0] accel_y;
        logic                     ov;
    } t_kicked;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ov;
    } t_sat;

    function automatic t_sat sat32(input logic signed [SUM_W-1:0] v);
        t_sat r;
        if (v > SUM_W'(signed'(32'sh7FFF_FFFF))) begin
            r.val = 32'sh7FFF_FFFF;
            r.ov  = 1'b1;
        end else if (v < SUM_W'(signed'(32'sh8000_0000))) begin
            r.val = 32'sh8000_0000;
            r.ov  = 1'b1;
        end else begin
            r.val = v[DATA_W-1:0];
            r.ov  = 1'b0;
        end
        return r;
    endfunction

    // scale a Q32.32 product back to Q16.16, round half up
    function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(32768);
        return t[PROD_W-1:16];
    endfunction

endpackage

// ===== design/ppc_if.sv =====
// Valid/ready channel interfaces for input items, results and the time step write.
interface ppc_in_if;
    import ppc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ppc_out_if;
    import ppc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ppc_cfg_if;
    import ppc_pkg::*;
    logic            valid;
    logic            ready;
    logic [DT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/particle_predictor_corrector.sv =====
// Top level of the 2D particle predictor-corrector integrator.
// Throughput: one particle per cycle; the four-stage pipeline (input, kick and
// store access, multiply, round and saturate) moves as one and stalls only
// while the output register holds a beat that is not taken.
// Reset clears valid bits and the time step; start stores are not cleared.
module particle_predictor_corrector
    import ppc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    ppc_in_if.sink          i_in,
    ppc_cfg_if.sink         i_cfg,
    ppc_out_if.source       o_out
);
    logic [DT_W-1:0] r_dt;
    logic            r_s0_vld, r_s1_vld, r_s2_vld, r_out_vld;
    t_in_item        r_s0;
    t_kicked         r_s1;
    t_out_item       r_out;
    t_kicked         n_s1;
    t_out_item       n_out;
    t_store_wr       wr;
    t_start          start;
    t_sat            vk_x, vk_y;
    logic            adv;

    assign adv         = !r_out_vld || o_out.ready;
    assign i_in.ready  = adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= '0;
        end else if (i_cfg.valid) begin
            r_dt <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_s0_vld  <= i_in.valid;
            r_s1_vld  <= r_s0_vld;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0  <= i_in.data;
            r_s1  <= n_s1;
            r_out <= n_out;
        end
    end

    // kicked velocity, saturated; used by every later step except in the unused mode
    assign vk_x = sat32(SUM_W'(r_s0.vel_x) + SUM_W'(r_s0.kick_x));
    assign vk_y = sat32(SUM_W'(r_s0.vel_y) + SUM_W'(r_s0.kick_y));

    always_comb begin
        n_s1.mode    = r_s0.mode;
        n_s1.idx     = r_s0.particle_index;
        n_s1.pos_x   = r_s0.pos_x;
        n_s1.pos_y   = r_s0.pos_y;
        n_s1.accel_x = r_s0.accel_x;
        n_s1.accel_y = r_s0.accel_y;
        if (r_s0.mode == MODE_UNUSED) begin
            n_s1.vel_x = r_s0.vel_x;
            n_s1.vel_y = r_s0.vel_y;
            n_s1.ov    = 1'b0;
        end else begin
            n_s1.vel_x = vk_x.val;
            n_s1.vel_y = vk_y.val;
            n_s1.ov    = vk_x.ov | vk_y.ov;
        end
    end

    // predictor writes the starts; the item right behind it already reads the new values
    assign wr.en         = adv && r_s0_vld && (r_s0.mode == MODE_PREDICT);
    assign wr.addr       = r_s0.particle_index[ADDR_W-1:0];
    assign wr.data.pos_x = r_s0.pos_x;
    assign wr.data.pos_y = r_s0.pos_y;
    assign wr.data.vel_x = vk_x.val;
    assign wr.data.vel_y = vk_y.val;

    ppc_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (adv),
        .i_rd_addr (r_s0.particle_index[ADDR_W-1:0]),
        .o_start   (start)
    );

    ppc_step u_step (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_dt    (r_dt),
        .i_item  (r_s1),
        .i_start (start),
        .o_res   (n_out)
    );

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;
endmodule

// ===== design/ppc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ppc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/ppc_store.sv =====
// Start position and start velocity stores, one RAM per component.
module ppc_store
    import ppc_pkg::*;
(
    input  logic              i_clk,
    input  t_store_wr         i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_start            o_start
);
    ppc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_PARTICLES)) u_pos_x (
        .i_clk(i_clk), .i_we(i_wr.en), .i_waddr(i_wr.addr), .i_wdata(i_wr.data.pos_x),
        .i_re(i_rd_en), .i_raddr(i_rd_addr), .o_rdata(o_start.pos_x)
    );
    ppc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_PARTICLES)) u_pos_y (
        .i_clk(i_clk), .i_we(i_wr.en), .i_waddr(i_wr.addr), .i_wdata(i_wr.data.pos_y),
        .i_re(i_rd_en), .i_raddr(i_rd_addr), .o_rdata(o_start.pos_y)
    );
    ppc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_PARTICLES)) u_vel_x (
        .i_clk(i_clk), .i_we(i_wr.en), .i_waddr(i_wr.addr), .i_wdata(i_wr.data.vel_x),
        .i_re(i_rd_en), .i_raddr(i_rd_addr), .o_rdata(o_start.vel_x)
    );
    ppc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_PARTICLES)) u_vel_y (
        .i_clk(i_clk), .i_we(i_wr.en), .i_waddr(i_wr.addr), .i_wdata(i_wr.data.vel_y),
        .i_re(i_rd_en), .i_raddr(i_rd_addr), .o_rdata(o_start.vel_y)
    );
endmodule

// ===== design/ppc_step.sv =====
// Multiply by the time step, round, midpoint or add starts by mode, saturate.
module ppc_step
    import ppc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_adv,
    input  logic [DT_W-1:0] i_dt,
    input  t_kicked         i_item,
    input  t_start          i_start,
    output t_out_item       o_res
);
    t_kicked                  r_item;
    t_start                   r_start;
    logic signed [PROD_W-1:0] r_pv_x, r_pv_y, r_pa_x, r_pa_y;
    logic signed [PROD_W-1:0] n_pv_x, n_pv_y, n_pa_x, n_pa_y;
    logic signed [DT_W:0]     dt_s;

    assign dt_s   = $signed({1'b0, i_dt});
    assign n_pv_x = PROD_W'(i_item.vel_x * dt_s);
    assign n_pv_y = PROD_W'(i_item.vel_y * dt_s);
    assign n_pa_x = PROD_W'(i_item.accel_x * dt_s);
    assign n_pa_y = PROD_W'(i_item.accel_y * dt_s);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item  <= i_item;
            r_start <= i_start;
            r_pv_x  <= n_pv_x;
            r_pv_y  <= n_pv_y;
            r_pa_x  <= n_pa_x;
            r_pa_y  <= n_pa_y;
        end
    end

    logic signed [SUM_W-1:0] dpx, dpy, dvx, dvy;
    logic signed [SUM_W-1:0] px, py, vx, vy;
    logic signed [SUM_W-1:0] sum_px, sum_py, sum_vx, sum_vy;
    t_sat                    s_px, s_py, s_vx, s_vy;

    assign dpx = SUM_W'(round_q16(r_pv_x));
    assign dpy = SUM_W'(round_q16(r_pv_y));
    assign dvx = SUM_W'(round_q16(r_pa_x));
    assign dvy = SUM_W'(round_q16(r_pa_y));
    assign px  = SUM_W'(r_item.pos_x);
    assign py  = SUM_W'(r_item.pos_y);
    assign vx  = SUM_W'(r_item.vel_x);
    assign vy  = SUM_W'(r_item.vel_y);

    always_comb begin
        unique case (r_item.mode)
            MODE_PREDICT: begin
                // midpoint: floor((a + (a + d)) / 2)
                sum_px = (px + px + dpx) >>> 1;
                sum_py = (py + py + dpy) >>> 1;
                sum_vx = (vx + vx + dvx) >>> 1;
                sum_vy = (vy + vy + dvy) >>> 1;
            end
            MODE_CORRECT: begin
                sum_px = SUM_W'(r_start.pos_x) + dpx;
                sum_py = SUM_W'(r_start.pos_y) + dpy;
                sum_vx = SUM_W'(r_start.vel_x) + dvx;
                sum_vy = SUM_W'(r_start.vel_y) + dvy;
            end
            default: begin
                // random kick and unused code: pass position, velocity as carried
                sum_px = px;
                sum_py = py;
                sum_vx = vx;
                sum_vy = vy;
            end
        endcase
    end

    assign s_px = sat32(sum_px);
    assign s_py = sat32(sum_py);
    assign s_vx = sat32(sum_vx);
    assign s_vy = sat32(sum_vy);

    assign o_res.out_index = r_item.idx;
    assign o_res.new_pos_x = s_px.val;
    assign o_res.new_pos_y = s_py.val;
    assign o_res.new_vel_x = s_vx.val;
    assign o_res.new_vel_y = s_vy.val;
    assign o_res.overflow  = r_item.ov | s_px.ov | s_py.ov | s_vx.ov | s_vy.ov;
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the particle predictor-corrector integrator.
module tb_top;
    import ppc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned  RUN_LIMIT   = 400000;
    localparam int unsigned  PHASE_ITEMS = 107;
    localparam int unsigned  REPORT_MAX  = 10;
    localparam longint       SAT_HI      = 64'sd2147483647;
    localparam longint       SAT_LO      = -SAT_HI - 1;
    localparam logic [31:0]  Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0]  Q_MIN       = 32'h8000_0000;
    localparam logic [31:0]  Q_ONE       = 32'h0001_0000;

    // Tracks the step setting and start stores, and holds the updates still owed.
    class motion_board;
        logic [DT_W-1:0]          step = '0;
        logic signed [DATA_W-1:0] start_px [MAX_PARTICLES];
        logic signed [DATA_W-1:0] start_py [MAX_PARTICLES];
        logic signed [DATA_W-1:0] start_vx [MAX_PARTICLES];
        logic signed [DATA_W-1:0] start_vy [MAX_PARTICLES];
        t_out_item                owed_updates [$];
        int unsigned              mismatches = 0;
        int unsigned              checked = 0;
        int unsigned              saturated = 0;
        int unsigned              mode_hits [4] = '{0, 0, 0, 0};

        function void set_step(logic [DT_W-1:0] v);
            step = v;
        endfunction

        function longint clamp32(longint v, inout bit ov);
            if (v > SAT_HI) begin
                ov = 1'b1;
                return SAT_HI;
            end
            if (v < SAT_LO) begin
                ov = 1'b1;
                return SAT_LO;
            end
            return v;
        endfunction

        // value * dt, back to Q16.16 with round half up
        function longint times_step(longint a);
            longint p;
            longint dt;
            dt = longint'(step);
            p = a * dt;
            return (p + 64'sd32768) >>> 16;
        endfunction

        function void note_particle(t_in_item it);
            t_out_item r;
            bit        ov;
            longint    px, py, vx, vy, kx, ky, ax, ay, ukx, uky;
            px = longint'(signed'(it.pos_x));
            py = longint'(signed'(it.pos_y));
            vx = longint'(signed'(it.vel_x));
            vy = longint'(signed'(it.vel_y));
            kx = longint'(signed'(it.kick_x));
            ky = longint'(signed'(it.kick_y));
            ax = longint'(signed'(it.accel_x));
            ay = longint'(signed'(it.accel_y));
            ov = 1'b0;
            r.out_index = it.particle_index;
            r.new_pos_x = it.pos_x;
            r.new_pos_y = it.pos_y;
            r.new_vel_x = it.vel_x;
            r.new_vel_y = it.vel_y;
            mode_hits[it.mode]++;
            if (it.mode != MODE_UNUSED) begin
                ukx = clamp32(vx + kx, ov);
                uky = clamp32(vy + ky, ov);
                case (it.mode)
                    MODE_PREDICT: begin
                        start_px[it.particle_index] = it.pos_x;
                        start_py[it.particle_index] = it.pos_y;
                        start_vx[it.particle_index] = ukx[DATA_W-1:0];
                        start_vy[it.particle_index] = uky[DATA_W-1:0];
                        r.new_pos_x = DATA_W'(clamp32((px + px + times_step(ukx)) >>> 1, ov));
                        r.new_pos_y = DATA_W'(clamp32((py + py + times_step(uky)) >>> 1, ov));
                        r.new_vel_x = DATA_W'(clamp32((ukx + ukx + times_step(ax)) >>> 1, ov));
                        r.new_vel_y = DATA_W'(clamp32((uky + uky + times_step(ay)) >>> 1, ov));
                    end
                    MODE_CORRECT: begin
                        r.new_pos_x = DATA_W'(clamp32(longint'(start_px[it.particle_index])
                                                      + times_step(ukx), ov));
                        r.new_pos_y = DATA_W'(clamp32(longint'(start_py[it.particle_index])
                                                      + times_step(uky), ov));
                        r.new_vel_x = DATA_W'(clamp32(longint'(start_vx[it.particle_index])
                                                      + times_step(ax), ov));
                        r.new_vel_y = DATA_W'(clamp32(longint'(start_vy[it.particle_index])
                                                      + times_step(ay), ov));
                    end
                    default: begin
                        r.new_vel_x = ukx[DATA_W-1:0];
                        r.new_vel_y = uky[DATA_W-1:0];
                    end
                endcase
            end
            r.overflow = ov;
            owed_updates.push_back(r);
        endfunction

        function void check_update(t_out_item got);
            t_out_item want;
            if (owed_updates.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected result beat: %p", got);
                mismatches++;
                return;
            end
            want = owed_updates.pop_front();
            checked++;
            if (got.overflow === 1'b1)
                saturated++;
            if (got.out_index !== want.out_index || got.new_pos_x !== want.new_pos_x
                    || got.new_pos_y !== want.new_pos_y || got.new_vel_x !== want.new_vel_x
                    || got.new_vel_y !== want.new_vel_y || got.overflow !== want.overflow) begin
                if (mismatches < REPORT_MAX) begin
                    $display("mismatch at result %0d", checked);
                    $display("  expected idx %0d pos %h %h vel %h %h ovf %b", want.out_index,
                             want.new_pos_x, want.new_pos_y, want.new_vel_x, want.new_vel_y,
                             want.overflow);
                    $display("  actual   idx %0d pos %h %h vel %h %h ovf %b", got.out_index,
                             got.new_pos_x, got.new_pos_y, got.new_vel_x, got.new_vel_y,
                             got.overflow);
                end
                mismatches++;
            end
        endfunction

        function int unsigned owed();
            return owed_updates.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    ppc_in_if    in_ch ();
    ppc_out_if   out_ch ();
    ppc_cfg_if   cfg_ch ();

    motion_board board;
    bit          in_quiet;
    bit          out_quiet;
    int unsigned step_settings;
    logic [11:0] warm_idx [$];

    particle_predictor_corrector i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[particle_predictor_corrector] ERROR");
        $finish;
    end

    // result side: stall at random, check every beat taken
    initial begin
        int unsigned stall;
        out_quiet = 1'b0;
        forever begin
            stall = out_quiet ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            board.check_update(out_ch.data);
            if ($urandom_range(0, 15) == 0)
                out_quiet = !out_quiet;
        end
    end

    task automatic write_step(input logic [DT_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        board.set_step(v);
        step_settings++;
    endtask

    task automatic send_particle(input t_in_item it);
        int unsigned gap;
        gap = in_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        board.note_particle(it);
        if ($urandom_range(0, 15) == 0)
            in_quiet = !in_quiet;
    endtask

    // drop valid, let every owed update come back, then let the pipeline settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.owed() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic t_in_item particle(logic [1:0] mode, logic [11:0] idx,
                                          logic [31:0] px, logic [31:0] py,
                                          logic [31:0] vx, logic [31:0] vy,
                                          logic [31:0] kx, logic [31:0] ky,
                                          logic [31:0] ax, logic [31:0] ay);
        t_in_item it;
        it.mode           = mode;
        it.particle_index = idx;
        it.pos_x          = px;
        it.pos_y          = py;
        it.vel_x          = vx;
        it.vel_y          = vy;
        it.kick_x         = kx;
        it.kick_y         = ky;
        it.accel_x        = ax;
        it.accel_y        = ay;
        return it;
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 11))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3, 4, 5: return 32'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [11:0] pick_index();
        if ($urandom_range(0, 3) == 0)
            return 12'($urandom_range(0, 4095));
        return $urandom_range(0, 1) ? 12'($urandom_range(0, 15))
                                    : 12'(4095 - $urandom_range(0, 15));
    endfunction

    // mostly predictor-then-corrector pairs on recently predicted particles
    task automatic send_random_particle();
        int unsigned pick;
        logic [1:0]  mode;
        logic [11:0] idx;
        pick = $urandom_range(0, 99);
        if (pick >= 40 && pick < 75 && warm_idx.size() != 0) begin
            mode = MODE_CORRECT;
            idx  = warm_idx[$urandom_range(0, warm_idx.size() - 1)];
        end else if (pick < 75) begin
            mode = MODE_PREDICT;
            idx  = pick_index();
            warm_idx.push_back(idx);
            if (warm_idx.size() > 24)
                void'(warm_idx.pop_front());
        end else if (pick < 93) begin
            mode = MODE_RANDOM;
            idx  = 12'($urandom_range(0, 4095));
        end else begin
            mode = MODE_UNUSED;
            idx  = 12'($urandom_range(0, 4095));
        end
        send_particle(particle(mode, idx, rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                               rand_q16(), rand_q16(), rand_q16(), rand_q16()));
    endtask

    initial begin
        logic [DT_W-1:0] step_plan [7];
        board         = new;
        in_quiet      = 1'b0;
        step_settings = 0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.data    <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_step(DT_W'(Q_ONE));
        // corrector right behind its predictor on the same particle
        send_particle(particle(MODE_PREDICT, 12'd0, Q_ONE, 32'hFFFF_0000, 32'h0002_0000,
                               32'hFFFE_8000, 32'h0000_8000, 32'h0, 32'h0001_0000,
                               32'hFFFF_0000));
        send_particle(particle(MODE_CORRECT, 12'd0, 32'h0, 32'h0, 32'h0002_0000,
                               32'hFFFE_8000, 32'h0000_8000, 32'h0, 32'h0003_0000,
                               32'hFFFD_0000));
        send_particle(particle(MODE_RANDOM, 12'd5, 32'h1234_5678, 32'h8765_4321,
                               32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_8000, 32'h0000_8000,
                               32'h0, 32'h0));
        // unused mode passes everything unchanged
        send_particle(particle(MODE_UNUSED, 12'd4095, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                               Q_MIN, Q_MAX, Q_MIN));
        // kick saturates and the midpoint overflows
        send_particle(particle(MODE_PREDICT, 12'd4095, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                               Q_MIN, Q_MAX, Q_MIN));
        send_particle(particle(MODE_CORRECT, 12'd4095, 32'h0, 32'h0, Q_MIN, Q_MAX, Q_MIN,
                               Q_MAX, Q_MIN, Q_MAX));
        send_particle(particle(MODE_PREDICT, 12'd1, Q_MIN, Q_MAX, 32'h0, 32'h0, 32'h0, 32'h0,
                               Q_MAX, Q_MAX));
        send_particle(particle(MODE_PREDICT, 12'd2, 32'h0, 32'h0, 32'hFFFF_FFFF,
                               32'h8000_0001, 32'hFFFF_FFFF, 32'h0, Q_MIN, Q_MIN));
        send_particle(particle(MODE_RANDOM, 12'd3, 32'h0, 32'h0, Q_MAX, Q_MIN, 32'h1,
                               32'hFFFF_FFFF, 32'h0, 32'h0));
        send_particle(particle(MODE_RANDOM, 12'hAAA, 32'h0, 32'h0, Q_MIN, Q_MAX, 32'hFFFF_FFFF,
                               32'h1, 32'h0, 32'h0));
        // start position near the top, corrector pushes it over
        send_particle(particle(MODE_PREDICT, 12'd7, 32'h7FFF_0000, 32'h8001_0000, 32'h0,
                               32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
        send_particle(particle(MODE_CORRECT, 12'd7, 32'h0, 32'h0, 32'h0100_0000,
                               32'hFF00_0000, 32'h0, 32'h0, Q_MAX, Q_MIN));
        send_particle(particle(MODE_CORRECT, 12'd1, 32'h0, 32'h0, 32'hFFFF_8000,
                               32'h0000_8000, 32'h0, 32'h0, Q_MIN, Q_MAX));
        send_particle(particle(MODE_CORRECT, 12'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h5555_5555,
                               32'hAAAA_AAAA));
        drain();

        step_plan = '{DT_W'(Q_MAX), '0, DT_W'(1), DT_W'(32'h8000), DT_W'($urandom),
                      DT_W'(Q_ONE), DT_W'($urandom_range(0, 32'h4_0000))};
        foreach (step_plan[p]) begin
            write_step(step_plan[p]);
            repeat (PHASE_ITEMS) send_random_particle();
            drain();
        end

        $display("checked %0d results: %0d predict, %0d correct, %0d kick only, %0d unused",
                 board.checked, board.mode_hits[MODE_PREDICT], board.mode_hits[MODE_CORRECT],
                 board.mode_hits[MODE_RANDOM], board.mode_hits[MODE_UNUSED]);
        $display("%0d step settings, %0d saturated results, %0d mismatches, %0d still owed",
                 step_settings, board.saturated, board.mismatches, board.owed());
        if (board.mismatches == 0 && board.owed() == 0) begin
            $display("[particle_predictor_corrector] OK");
        end else begin
            $display("[particle_predictor_corrector] ERROR");
        end
        $finish;
    end

endmodule
